// ===== design/hl2d_pkg.sv =====
// ----------------------------------------------------------------------------
// hl2d_pkg
// Shared constants, register indexes and types of the 2D Haar lifting block.
// ----------------------------------------------------------------------------
package hl2d_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_HEIGHT      = 4096;

    localparam int ROW_BITS  = 12;
    localparam int COL_BITS  = 10;
    localparam int COEF_BITS = 22;

    localparam int COEF_MAX = 2097151;
    localparam int COEF_MIN = -2097152;

    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_INDEX_BITS  = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;

    // results per sample, and the output queue that absorbs them
    localparam int OUT_MAX        = 4;
    localparam int OUT_COUNT_BITS = 3;
    localparam int OUT_FIFO_DEPTH = 8;

    // what the column stage does with the row values of one sample
    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_ODD   = 2'd1;
    localparam logic [1:0] MODE_LAST  = 2'd2;

    typedef struct packed {
        logic       pair;
        logic       single;
        logic [1:0] mode;
    } lift_ctrl_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]         row_index;
        logic [COL_BITS-1:0]         col_index;
        logic signed [COEF_BITS-1:0] coefficient;
        logic                        last;
    } result_t;

endpackage

// ===== design/hl2d_ifs.sv =====
// ----------------------------------------------------------------------------
// hl2d interfaces
// Sample stream, coefficient stream and configuration write channel.
// ----------------------------------------------------------------------------
interface hl2d_sample_if #(
    parameter int SAMPLE_BITS = hl2d_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface hl2d_result_if;
    logic                                    valid;
    logic                                    ready;
    logic [hl2d_pkg::ROW_BITS-1:0]           row_index;
    logic [hl2d_pkg::COL_BITS-1:0]           col_index;
    logic signed [hl2d_pkg::COEF_BITS-1:0]   coefficient;
    logic                                    last;

    modport source (output valid, output row_index, output col_index,
                    output coefficient, output last, input ready);
    modport sink   (input valid, input row_index, input col_index,
                    input coefficient, input last, output ready);
endinterface

interface hl2d_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hl2d_pkg::CFG_INDEX_BITS-1:0] index;
    logic [hl2d_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/hl2d_row_lift.sv =====
// ----------------------------------------------------------------------------
// hl2d_row_lift
// Raster counters and horizontal lifting; registers the row values of each
// sample that completes a pair or ends an odd-width row.
// ----------------------------------------------------------------------------
module hl2d_row_lift #(
    parameter int MAX_WIDTH   = hl2d_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = hl2d_pkg::SAMPLE_BITS_DEF,
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = SAMPLE_BITS + 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    hl2d_sample_if.sink                     pixels,
    input  logic                            restart,
    input  logic [CW-1:0]                   w_last,
    input  logic [hl2d_pkg::ROW_BITS-1:0]   h_last,
    output logic                            a_valid,
    input  logic                            a_ready,
    output hl2d_pkg::lift_ctrl_t            a_ctrl,
    output logic [hl2d_pkg::ROW_BITS-1:0]   a_row,
    output logic [CW-1:0]                   a_col,
    output logic signed [RW-1:0]            a_rv0,
    output logic signed [RW-1:0]            a_rv1
);

    localparam int DW = SAMPLE_BITS + 1;

    logic [CW-1:0]                   col_reg, col_next;
    logic [hl2d_pkg::ROW_BITS-1:0]   row_reg, row_next;
    logic signed [SAMPLE_BITS-1:0]   prev_px_reg;
    logic signed [DW-1:0]            prev_d_reg;
    logic                            a_valid_reg;

    logic signed [SAMPLE_BITS-1:0]   px;
    logic signed [DW-1:0]            d;
    logic                            accept;
    hl2d_pkg::lift_ctrl_t            ctrl;
    logic [CW-1:0]                   col0;
    logic signed [RW-1:0]            rv0, rv1;

    assign px            = SAMPLE_BITS'(pixels.sample);
    assign pixels.ready  = !a_valid_reg || a_ready;
    assign accept        = pixels.valid && pixels.ready;
    assign a_valid       = a_valid_reg;

    always_comb
    begin
        d           = DW'(px) - DW'(prev_px_reg);
        ctrl.pair   = col_reg[0];
        ctrl.single = !col_reg[0] && (col_reg == w_last);
        if (row_reg[0])
        begin
            ctrl.mode = hl2d_pkg::MODE_ODD;
        end
        else if (row_reg == h_last)
        begin
            ctrl.mode = hl2d_pkg::MODE_LAST;
        end
        else
        begin
            ctrl.mode = hl2d_pkg::MODE_STORE;
        end

        if (col_reg[0])
        begin
            // even + d/2 and d, both in halves
            rv0  = RW'(prev_px_reg) + RW'(px);
            rv1  = $signed({d, 1'b0});
            col0 = col_reg - CW'(1);
        end
        else
        begin
            // unpaired last column borrows the neighbouring detail
            rv0  = RW'($signed({px, 1'b0})) + RW'(prev_d_reg);
            rv1  = '0;
            col0 = col_reg;
        end

        col_next = col_reg;
        row_next = row_reg;
        if (col_reg == w_last)
        begin
            col_next = '0;
            row_next = (row_reg == h_last) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            prev_px_reg <= '0;
            prev_d_reg  <= '0;
            a_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            prev_px_reg <= '0;
            prev_d_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                prev_px_reg <= px;
                if (col_reg[0])
                begin
                    prev_d_reg <= d;
                end
                // drop samples that only feed the pair register
                a_valid_reg <= ctrl.pair || ctrl.single;
            end
            else if (a_ready)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_ctrl <= ctrl;
            a_row  <= row_reg;
            a_col  <= col0;
            a_rv0  <= rv0;
            a_rv1  <= rv1;
        end
    end

endmodule

// ===== design/hl2d_col_lift.sv =====
// ----------------------------------------------------------------------------
// hl2d_col_lift
// Vertical lifting against two line memories organized by column pair:
// one holds the row values of the last even row, one the column details of
// the last odd row. Read on entry, write back when the item leaves.
// ----------------------------------------------------------------------------
module hl2d_col_lift #(
    parameter int MAX_WIDTH   = hl2d_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = hl2d_pkg::SAMPLE_BITS_DEF,
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = SAMPLE_BITS + 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  a_valid,
    output logic                                  a_ready,
    input  hl2d_pkg::lift_ctrl_t                  a_ctrl,
    input  logic [hl2d_pkg::ROW_BITS-1:0]         a_row,
    input  logic [CW-1:0]                         a_col,
    input  logic signed [RW-1:0]                  a_rv0,
    input  logic signed [RW-1:0]                  a_rv1,
    input  logic                                  room,
    output logic                                  push,
    output logic [hl2d_pkg::OUT_COUNT_BITS-1:0]   push_count,
    output hl2d_pkg::result_t                     push_data [hl2d_pkg::OUT_MAX]
);

    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int XW    = (RW + 2 > hl2d_pkg::COEF_BITS) ? RW + 2 : hl2d_pkg::COEF_BITS;
    localparam logic signed [XW-1:0] SAT_HI = XW'(hl2d_pkg::COEF_MAX);
    localparam logic signed [XW-1:0] SAT_LO = XW'(hl2d_pkg::COEF_MIN);

    // Pair entries: an item that reads the entry the leaving item writes
    // is held until that item has left, so the write has landed before the read issues.
    logic [2*RW-1:0]       even_mem   [DEPTH];
    logic [2*(RW+1)-1:0]   detail_mem [DEPTH];

    logic [2*RW-1:0]                even_rd_reg;
    logic [2*(RW+1)-1:0]            detail_rd_reg;
    logic                           b_valid_reg;
    hl2d_pkg::lift_ctrl_t           b_ctrl_reg;
    logic [hl2d_pkg::ROW_BITS-1:0]  b_row_reg;
    logic [CW-1:0]                  b_col_reg;
    logic [AW-1:0]                  b_addr_reg;
    logic signed [RW-1:0]           b_rv0_reg, b_rv1_reg;

    logic [AW-1:0]                  a_addr;
    logic                           take;
    logic                           b_go;
    logic                           b_writes;
    logic                           clash;
    logic signed [RW-1:0]           ev0, ev1;
    logic signed [RW:0]             cd0, cd1;
    logic signed [RW:0]             dd0, dd1;
    logic signed [XW-1:0]           s0, s1, d0, d1, l0, l1;
    logic [CW-1:0]                  col1;
    logic [hl2d_pkg::ROW_BITS-1:0]  row_up;
    logic [hl2d_pkg::OUT_COUNT_BITS-1:0] n;
    hl2d_pkg::result_t              res [hl2d_pkg::OUT_MAX];

    function automatic logic signed [hl2d_pkg::COEF_BITS-1:0] sat(
        input logic signed [XW-1:0] v
    );
        logic signed [hl2d_pkg::COEF_BITS-1:0] r;
        if (v > SAT_HI)
        begin
            r = hl2d_pkg::COEF_BITS'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = hl2d_pkg::COEF_BITS'(SAT_LO);
        end
        else
        begin
            r = hl2d_pkg::COEF_BITS'(v);
        end
        return r;
    endfunction

    function automatic hl2d_pkg::result_t mk(
        input logic [hl2d_pkg::ROW_BITS-1:0] r,
        input logic [CW-1:0]                 c,
        input logic signed [XW-1:0]          v
    );
        hl2d_pkg::result_t t;
        t.row_index   = r;
        t.col_index   = hl2d_pkg::COL_BITS'(c);
        t.coefficient = sat(v);
        t.last        = 1'b0;
        return t;
    endfunction

    assign a_addr   = AW'(a_col >> 1);
    assign b_writes = (b_ctrl_reg.mode == hl2d_pkg::MODE_STORE) ||
                      (b_ctrl_reg.mode == hl2d_pkg::MODE_ODD);
    // hold the read while the leaving item still writes the same entry
    assign clash    = b_valid_reg && a_valid && b_writes && (b_addr_reg == a_addr);
    assign a_ready  = (!b_valid_reg || room) && !clash;
    assign take     = a_valid && a_ready;
    assign b_go     = b_valid_reg && room;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            even_rd_reg   <= even_mem[a_addr];
            detail_rd_reg <= detail_mem[a_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go && b_ctrl_reg.mode == hl2d_pkg::MODE_STORE)
        begin
            even_mem[b_addr_reg] <= {b_rv1_reg, b_rv0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go && b_ctrl_reg.mode == hl2d_pkg::MODE_ODD)
        begin
            detail_mem[b_addr_reg] <= {dd1, dd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_go)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            b_ctrl_reg <= a_ctrl;
            b_row_reg  <= a_row;
            b_col_reg  <= a_col;
            b_addr_reg <= a_addr;
            b_rv0_reg  <= a_rv0;
            b_rv1_reg  <= a_rv1;
        end
    end

    always_comb
    begin
        ev0 = $signed(even_rd_reg[RW-1:0]);
        ev1 = $signed(even_rd_reg[2*RW-1:RW]);
        cd0 = $signed(detail_rd_reg[RW:0]);
        cd1 = $signed(detail_rd_reg[2*(RW+1)-1:RW+1]);

        dd0 = (RW+1)'(b_rv0_reg) - (RW+1)'(ev0);
        dd1 = (RW+1)'(b_rv1_reg) - (RW+1)'(ev1);

        // quarters: smooth = 2a + dd, detail = 2dd, last row = 2rv + stored dd
        s0 = XW'(ev0) + XW'(b_rv0_reg);
        s1 = XW'(ev1) + XW'(b_rv1_reg);
        d0 = XW'(dd0) + XW'(dd0);
        d1 = XW'(dd1) + XW'(dd1);
        l0 = XW'(b_rv0_reg) + XW'(b_rv0_reg) + XW'(cd0);
        l1 = XW'(b_rv1_reg) + XW'(b_rv1_reg) + XW'(cd1);

        col1   = b_col_reg + CW'(1);
        row_up = b_row_reg - 1'b1;

        for (int i = 0; i < hl2d_pkg::OUT_MAX; i++)
        begin
            res[i] = mk(b_row_reg, b_col_reg, l0);
        end
        n = '0;

        case (b_ctrl_reg.mode)
            hl2d_pkg::MODE_ODD:
            begin
                if (b_ctrl_reg.pair)
                begin
                    res[0] = mk(row_up, b_col_reg, s0);
                    res[1] = mk(row_up, col1, s1);
                    res[2] = mk(b_row_reg, b_col_reg, d0);
                    res[3] = mk(b_row_reg, col1, d1);
                    n      = 3'd4;
                end
                else
                begin
                    res[0] = mk(row_up, b_col_reg, s0);
                    res[1] = mk(b_row_reg, b_col_reg, d0);
                    n      = 3'd2;
                end
            end
            hl2d_pkg::MODE_LAST:
            begin
                res[0] = mk(b_row_reg, b_col_reg, l0);
                res[1] = mk(b_row_reg, col1, l1);
                n      = b_ctrl_reg.pair ? 3'd2 : 3'd1;
            end
            default:
            begin
                n = '0;
            end
        endcase

        for (int i = 0; i < hl2d_pkg::OUT_MAX; i++)
        begin
            res[i].last = (hl2d_pkg::OUT_COUNT_BITS'(i + 1) == n);
        end
    end

    assign push       = b_go;
    assign push_count = n;
    assign push_data  = res;

endmodule

// ===== design/hl2d_out_fifo.sv =====
// ----------------------------------------------------------------------------
// hl2d_out_fifo
// Result queue: takes up to four results in a cycle while it has room, hands out one a beat.
// ----------------------------------------------------------------------------
module hl2d_out_fifo (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic [hl2d_pkg::OUT_COUNT_BITS-1:0]   push_count,
    input  hl2d_pkg::result_t                     push_data [hl2d_pkg::OUT_MAX],
    output logic                                  room,
    hl2d_result_if.source                         coeffs
);

    localparam int DEPTH = hl2d_pkg::OUT_FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    hl2d_pkg::result_t  entry_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]        count_reg, count_next;
    logic               pop;
    logic [PW:0]        added;
    hl2d_pkg::result_t  head;

    assign pop   = coeffs.valid && coeffs.ready;
    assign added = push ? (PW+1)'(push_count) : '0;
    assign room  = count_reg <= (PW+1)'(DEPTH - hl2d_pkg::OUT_MAX);

    always_comb
    begin
        count_next = count_reg + added - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(added);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < hl2d_pkg::OUT_MAX; i++)
        begin
            if (push && hl2d_pkg::OUT_COUNT_BITS'(i) < push_count)
            begin
                entry_reg[wr_ptr_reg + PW'(i)] <= push_data[i];
            end
        end
    end

    assign head               = entry_reg[rd_ptr_reg];
    assign coeffs.valid       = count_reg != '0;
    assign coeffs.row_index   = head.row_index;
    assign coeffs.col_index   = head.col_index;
    assign coeffs.coefficient = head.coefficient;
    assign coeffs.last        = head.last;

endmodule

// ===== design/haar_lifting_2d.sv =====
// ----------------------------------------------------------------------------
// haar_lifting_2d
// One-level 2D Haar lifting over a raster pixel stream, rows then columns.
// Path: a sample's row values are registered in the row stage, then pass the
//   line-memory read and column stage registers into the result queue.
// Throughput: one sample a cycle unless the column stage stalls; the result port
//   moves one result a beat, so odd rows, up to four per sample, run at that rate.
// Reset: counters and pair registers clear, width and height return to 512;
//   the line memories are not cleared.
// ----------------------------------------------------------------------------
module haar_lifting_2d #(
    parameter int MAX_WIDTH   = hl2d_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = hl2d_pkg::SAMPLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    hl2d_cfg_if.sink        cfg,
    hl2d_sample_if.sink     pixels,
    hl2d_result_if.source   coeffs
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = SAMPLE_BITS + 2;
    localparam int W_RST = (hl2d_pkg::WIDTH_RESET < MAX_WIDTH) ?
                           hl2d_pkg::WIDTH_RESET : MAX_WIDTH;
    localparam logic [CW-1:0] W_LAST_RST = CW'(W_RST - 1);
    localparam logic [hl2d_pkg::ROW_BITS-1:0] H_LAST_RST =
        hl2d_pkg::ROW_BITS'(hl2d_pkg::HEIGHT_RESET - 1);

    logic [CW-1:0]                     w_last_reg;
    logic [hl2d_pkg::ROW_BITS-1:0]     h_last_reg;
    logic                              cfg_write;
    logic [hl2d_pkg::WIDTH_REG_BITS-1:0]  w_raw;
    logic [hl2d_pkg::HEIGHT_REG_BITS-1:0] h_raw;
    logic [CW-1:0]                     w_last_next;
    logic [hl2d_pkg::ROW_BITS-1:0]     h_last_next;

    logic                              a_valid, a_ready;
    hl2d_pkg::lift_ctrl_t              a_ctrl;
    logic [hl2d_pkg::ROW_BITS-1:0]     a_row;
    logic [CW-1:0]                     a_col;
    logic signed [RW-1:0]              a_rv0, a_rv1;
    logic                              room, push;
    logic [hl2d_pkg::OUT_COUNT_BITS-1:0] push_count;
    hl2d_pkg::result_t                 push_data [hl2d_pkg::OUT_MAX];

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign w_raw     = hl2d_pkg::WIDTH_REG_BITS'(cfg.data);
    assign h_raw     = hl2d_pkg::HEIGHT_REG_BITS'(cfg.data);

    // clamp width to [2, MAX_WIDTH] and height to [2, MAX_HEIGHT]
    always_comb
    begin
        if (32'(w_raw) < 32'd2)
        begin
            w_last_next = CW'(1);
        end
        else if (32'(w_raw) > 32'(MAX_WIDTH))
        begin
            w_last_next = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last_next = CW'(w_raw - 1'b1);
        end

        if (32'(h_raw) < 32'd2)
        begin
            h_last_next = hl2d_pkg::ROW_BITS'(1);
        end
        else if (32'(h_raw) > 32'(hl2d_pkg::MAX_HEIGHT))
        begin
            h_last_next = hl2d_pkg::ROW_BITS'(hl2d_pkg::MAX_HEIGHT - 1);
        end
        else
        begin
            h_last_next = hl2d_pkg::ROW_BITS'(h_raw - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= W_LAST_RST;
            h_last_reg <= H_LAST_RST;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                hl2d_pkg::REG_IMAGE_WIDTH:  w_last_reg <= w_last_next;
                hl2d_pkg::REG_IMAGE_HEIGHT: h_last_reg <= h_last_next;
                default:                    w_last_reg <= w_last_reg;
            endcase
        end
    end

    hl2d_row_lift #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .restart (cfg_write),
        .w_last  (w_last_reg),
        .h_last  (h_last_reg),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_ctrl  (a_ctrl),
        .a_row   (a_row),
        .a_col   (a_col),
        .a_rv0   (a_rv0),
        .a_rv1   (a_rv1)
    );

    hl2d_col_lift #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_col (
        .clk        (clk),
        .rst_n      (rst_n),
        .a_valid    (a_valid),
        .a_ready    (a_ready),
        .a_ctrl     (a_ctrl),
        .a_row      (a_row),
        .a_col      (a_col),
        .a_rv0      (a_rv0),
        .a_rv1      (a_rv1),
        .room       (room),
        .push       (push),
        .push_count (push_count),
        .push_data  (push_data)
    );

    hl2d_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_count (push_count),
        .push_data  (push_data),
        .room       (room),
        .coeffs     (coeffs)
    );

endmodule

// ===== test/tb_haar_lifting_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haar_lifting_2d
// Streams pixel frames of many sizes through the 2D Haar lifting block and
// checks every coefficient beat against a line-buffer model of the lifting,
// with random stalls on the pixel and coefficient channels.
// ----------------------------------------------------------------------------
module tb_haar_lifting_2d;

    localparam int SBITS         = hl2d_pkg::SAMPLE_BITS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int STALL_LIMIT   = 2000;

    typedef enum logic [1:0] {OP_SAMPLE, OP_CONFIG, OP_PACE, OP_DRAIN} stim_op_t;

    typedef struct {
        stim_op_t                                op;
        logic signed [SBITS-1:0]                 sample;
        logic [hl2d_pkg::CFG_INDEX_BITS-1:0]     index;
        logic [hl2d_pkg::CFG_DATA_BITS-1:0]      data;
        int                                      src_pct;
        int                                      snk_pct;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n;

    hl2d_cfg_if                         cfg_bus ();
    hl2d_sample_if #(.SAMPLE_BITS(SBITS)) pix_bus ();
    hl2d_result_if                      coef_bus ();

    haar_lifting_2d u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .pixels (pix_bus),
        .coeffs (coef_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // pending stimulus and expected coefficients
    stim_t             pending [$];
    hl2d_pkg::result_t coef_q [$];
    int      n_predicted;
    int      n_checked;
    int      n_errors = 0;
    int      settle_cnt;
    int      src_idle;
    int      snk_idle;
    int      idle_cycles;

    // lifting model state
    logic [hl2d_pkg::WIDTH_REG_BITS-1:0]  width_reg;
    logic [hl2d_pkg::HEIGHT_REG_BITS-1:0] height_reg;
    logic signed [19:0]         even_line [hl2d_pkg::MAX_WIDTH_DEF];
    logic signed [20:0]         det_line [hl2d_pkg::MAX_WIDTH_DEF];
    logic signed [SBITS-1:0]    prev_px;
    logic signed [17:0]         prev_rdet;
    logic [hl2d_pkg::COL_BITS-1:0] col_cnt;
    logic [hl2d_pkg::ROW_BITS-1:0] row_cnt;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void clear_frame();
        prev_px   = '0;
        prev_rdet = '0;
        col_cnt   = '0;
        row_cnt   = '0;
    endfunction

    function automatic hl2d_pkg::result_t coef_at(input int row, input int col, input int v);
        hl2d_pkg::result_t r;
        r.row_index   = hl2d_pkg::ROW_BITS'(row);
        r.col_index   = hl2d_pkg::COL_BITS'(col);
        r.coefficient = hl2d_pkg::COEF_BITS'(v);
        r.last        = 1'b0;
        return r;
    endfunction

    // Lift one pixel, queue the coefficients it finalizes, return their count.
    function automatic int lift_sample(input logic signed [SBITS-1:0] px);
        int      w, h, col, row, nrow, d, a, n, k;
        int      rcol [2];
        int      rval [2];
        int      cdd [2];
        hl2d_pkg::result_t res [hl2d_pkg::OUT_MAX];
        w = (width_reg < 2) ? 2 :
            ((width_reg > hl2d_pkg::MAX_WIDTH_DEF) ? hl2d_pkg::MAX_WIDTH_DEF : int'(width_reg));
        h = (height_reg < 2) ? 2 :
            ((height_reg > hl2d_pkg::MAX_HEIGHT) ? hl2d_pkg::MAX_HEIGHT : int'(height_reg));
        col  = int'(col_cnt);
        row  = int'(row_cnt);
        nrow = 0;
        n    = 0;
        if (col >= w) col = w - 1;
        if (row >= h) row = h - 1;

        // row pass, half units
        if (col % 2 == 1)
        begin
            d         = int'(px) - int'(prev_px);
            rcol[0]   = col - 1;
            rval[0]   = 2 * int'(prev_px) + d;
            rcol[1]   = col;
            rval[1]   = 2 * d;
            prev_rdet = 18'(d);
            nrow      = 2;
        end
        else if (col == w - 1)
        begin
            // unpaired last column borrows the previous detail
            rcol[0] = col;
            rval[0] = 2 * int'(px) + int'(prev_rdet);
            nrow    = 1;
        end
        prev_px = px;

        // column pass, quarter units
        if (row % 2 == 1)
        begin
            for (k = 0; k < nrow; k++)
            begin
                a                 = int'(even_line[rcol[k]]);
                cdd[k]            = rval[k] - a;
                det_line[rcol[k]] = 21'(cdd[k]);
                res[n]            = coef_at(row - 1, rcol[k], 2 * a + cdd[k]);
                n++;
            end
            for (k = 0; k < nrow; k++)
            begin
                res[n] = coef_at(row, rcol[k], 2 * cdd[k]);
                n++;
            end
        end
        else if (row == h - 1)
        begin
            for (k = 0; k < nrow; k++)
            begin
                res[n] = coef_at(row, rcol[k], 2 * rval[k] + int'(det_line[rcol[k]]));
                n++;
            end
        end
        else
        begin
            for (k = 0; k < nrow; k++)
                even_line[rcol[k]] = 20'(rval[k]);
        end

        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_cnt = hl2d_pkg::COL_BITS'(col);
        row_cnt = hl2d_pkg::ROW_BITS'(row);

        for (k = 0; k < n; k++)
        begin
            res[k].last = (k == n - 1);
            coef_q.push_back(res[k]);
        end
        return n;
    endfunction

    // ---------------- stimulus building ----------------

    task automatic add_sample(input logic signed [SBITS-1:0] s);
        stim_t t;
        t.op     = OP_SAMPLE;
        t.sample = s;
        pending.push_back(t);
    endtask

    task automatic add_config(input logic [hl2d_pkg::CFG_INDEX_BITS-1:0] idx,
                              input logic [hl2d_pkg::CFG_DATA_BITS-1:0] dat);
        stim_t t;
        t.op    = OP_CONFIG;
        t.index = idx;
        t.data  = dat;
        pending.push_back(t);
    endtask

    task automatic add_pace(input int src, input int snk);
        stim_t t;
        t.op      = OP_PACE;
        t.src_pct = src;
        t.snk_pct = snk;
        pending.push_back(t);
    endtask

    task automatic add_drain();
        stim_t t;
        t.op = OP_DRAIN;
        pending.push_back(t);
    endtask

    function automatic logic signed [SBITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return SBITS'($urandom);
        endcase
    endfunction

    task automatic add_random_block(input int n_samples);
        logic [hl2d_pkg::CFG_DATA_BITS-1:0] wdat, hdat;
        int                                 k;
        case ($urandom_range(5))
            0:       wdat = hl2d_pkg::CFG_DATA_BITS'($urandom_range(1));
            // upper bits fall outside the width register
            1:       wdat = hl2d_pkg::CFG_DATA_BITS'(($urandom_range(3) << 11) |
                                                     $urandom_range(2, 9));
            default: wdat = hl2d_pkg::CFG_DATA_BITS'($urandom_range(2, 9));
        endcase
        case ($urandom_range(5))
            0:       hdat = hl2d_pkg::CFG_DATA_BITS'($urandom_range(1));
            1:       hdat = hl2d_pkg::CFG_DATA_BITS'($urandom);
            default: hdat = hl2d_pkg::CFG_DATA_BITS'($urandom_range(2, 7));
        endcase
        if ($urandom_range(3) != 0) add_config(hl2d_pkg::REG_IMAGE_WIDTH, wdat);
        if ($urandom_range(3) != 0) add_config(hl2d_pkg::REG_IMAGE_HEIGHT, hdat);
        for (k = 0; k < n_samples; k++)
            add_sample(pick_sample());
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin : drive
        logic                      px_fire, cf_fire, co_fire, pv_next, cv_next;
        logic signed [SBITS-1:0]   smp_next;
        logic [hl2d_pkg::CFG_INDEX_BITS-1:0] idx_next;
        logic [hl2d_pkg::CFG_DATA_BITS-1:0]  dat_next;
        int                        outstanding, quiet_next, src_next, snk_next, made;
        stim_t                     head;
        if (!rst_n)
        begin
            pix_bus.valid  <= 1'b0;
            pix_bus.sample <= '0;
            cfg_bus.valid  <= 1'b0;
            cfg_bus.index  <= '0;
            cfg_bus.data   <= '0;
            n_predicted    <= 0;
            settle_cnt     <= 0;
            src_idle       <= 0;
            snk_idle       <= 0;
            width_reg      = hl2d_pkg::WIDTH_REG_BITS'(hl2d_pkg::WIDTH_RESET);
            height_reg     = hl2d_pkg::HEIGHT_REG_BITS'(hl2d_pkg::HEIGHT_RESET);
            clear_frame();
        end
        else
        begin
            px_fire = pix_bus.valid && pix_bus.ready;
            cf_fire = cfg_bus.valid && cfg_bus.ready;
            co_fire = coef_bus.valid && coef_bus.ready;
            made    = 0;
            if (px_fire)
                made = lift_sample(pix_bus.sample);
            if (cf_fire)
            begin
                if (cfg_bus.index == hl2d_pkg::REG_IMAGE_WIDTH)
                    width_reg = cfg_bus.data[hl2d_pkg::WIDTH_REG_BITS-1:0];
                else
                    height_reg = cfg_bus.data[hl2d_pkg::HEIGHT_REG_BITS-1:0];
                clear_frame();
            end

            outstanding = n_predicted - n_checked;
            quiet_next  = (px_fire || cf_fire || co_fire || outstanding != 0) ? 0
                                                                             : settle_cnt + 1;
            pv_next  = pix_bus.valid && !px_fire;
            cv_next  = cfg_bus.valid && !cf_fire;
            smp_next = pix_bus.sample;
            idx_next = cfg_bus.index;
            dat_next = cfg_bus.data;
            src_next = src_idle;
            snk_next = snk_idle;

            if (!pv_next && !cv_next && pending.size() != 0)
            begin
                head = pending[0];
                case (head.op)
                    OP_SAMPLE:
                        if ($urandom_range(99) >= src_idle)
                        begin
                            void'(pending.pop_front());
                            pv_next  = 1'b1;
                            smp_next = head.sample;
                        end
                    OP_PACE:
                    begin
                        void'(pending.pop_front());
                        src_next = head.src_pct;
                        snk_next = head.snk_pct;
                    end
                    default:
                        // hold until every coefficient is back and the pipe has settled
                        if (outstanding == 0 && quiet_next >= SETTLE_CYCLES)
                        begin
                            void'(pending.pop_front());
                            if (head.op == OP_CONFIG)
                            begin
                                cv_next  = 1'b1;
                                idx_next = head.index;
                                dat_next = head.data;
                            end
                        end
                endcase
            end

            pix_bus.valid  <= pv_next;
            pix_bus.sample <= smp_next;
            cfg_bus.valid  <= cv_next;
            cfg_bus.index  <= idx_next;
            cfg_bus.data   <= dat_next;
            n_predicted    <= n_predicted + made;
            settle_cnt     <= quiet_next;
            src_idle       <= src_next;
            snk_idle       <= snk_next;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin : watch
        hl2d_pkg::result_t want;
        if (!rst_n)
        begin
            coef_bus.ready <= 1'b0;
            n_checked      <= 0;
        end
        else
        begin
            if (coef_bus.valid && coef_bus.ready)
            begin
                if (n_checked >= n_predicted)
                    report_error($sformatf("unexpected coefficient r%0d c%0d v%0d",
                                           coef_bus.row_index, coef_bus.col_index,
                                           coef_bus.coefficient));
                else
                begin
                    want = coef_q.pop_front();
                    if (coef_bus.row_index !== want.row_index ||
                        coef_bus.col_index !== want.col_index ||
                        coef_bus.coefficient !== want.coefficient ||
                        coef_bus.last !== want.last)
                        report_error($sformatf(
                            "beat %0d: got r%0d c%0d v%0d l%0b, want r%0d c%0d v%0d l%0b",
                            n_checked, coef_bus.row_index, coef_bus.col_index,
                            coef_bus.coefficient, coef_bus.last, want.row_index,
                            want.col_index, want.coefficient, want.last));
                    n_checked <= n_checked + 1;
                end
            end
            coef_bus.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((pix_bus.valid && pix_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
                 (coef_bus.valid && coef_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no beat for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------- sequence ----------------

    initial
    begin
        int k, b;
        rst_n          = 1'b0;
        pix_bus.valid  = 1'b0;
        pix_bus.sample = '0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = '0;
        cfg_bus.data   = '0;
        coef_bus.ready = 1'b0;

        // reset defaults: 512 wide, start of the first even row
        add_pace(16, 61);
        for (k = 0; k < 8; k++)
            add_sample(pick_sample());

        // odd width and height: unpaired column and unpaired last row
        add_config(hl2d_pkg::REG_IMAGE_WIDTH, 3);
        add_config(hl2d_pkg::REG_IMAGE_HEIGHT, 3);
        for (k = 0; k < 9; k++)
            add_sample((k % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        add_sample(16'sh8000);
        add_sample(16'sh0000);
        add_sample(-16'sd1);
        add_sample(16'sd1);
        add_sample(16'sh7FFF);
        // restart mid-frame
        add_config(hl2d_pkg::REG_IMAGE_HEIGHT, 3);
        for (k = 0; k < 9; k++)
            add_sample((k / 3 == 1) ? 16'sh7FFF : 16'sh8000);
        // below-range sizes clamp to 2x2
        add_config(hl2d_pkg::REG_IMAGE_WIDTH, 1);
        add_config(hl2d_pkg::REG_IMAGE_HEIGHT, 0);
        add_sample(16'sh7FFF);
        add_sample(16'sh8000);
        add_sample(16'sh8000);
        add_sample(16'sh7FFF);

        for (b = 0; b < 3; b++)
            add_random_block($urandom_range(6, 10));
        add_drain();

        add_pace(61, 16);
        for (b = 0; b < 3; b++)
            add_random_block($urandom_range(6, 10));

        add_pace(0, 0);
        for (b = 0; b < 3; b++)
            add_random_block($urandom_range(6, 10));

        // above-range width clamps to the full line
        add_config(hl2d_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
        add_config(hl2d_pkg::REG_IMAGE_HEIGHT, 2);
        for (k = 0; k < 12; k++)
            add_sample(pick_sample());

        // above-range height clamps to the tallest frame
        add_config(hl2d_pkg::REG_IMAGE_WIDTH, 0);
        add_config(hl2d_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
        for (k = 0; k < 12; k++)
            add_sample(pick_sample());
        add_drain();

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pending.size() != 0 || pix_bus.valid || cfg_bus.valid)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_checked != n_predicted)
            report_error($sformatf("%0d coefficients never arrived", n_predicted - n_checked));
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
